FILE: design/shf_pkg.sv
// Shared types, constants and mixing functions of the SuperFastHash engine.
// Used by shf_front, shf_fifo, shf_back, superfasthash_32 and tb; depends on nothing.
package shf_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int AVAL_STAGES = 3;

    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_TWO   = 3'd2;
    localparam logic [2:0] CNT_THREE = 3'd3;
    localparam logic [2:0] CNT_FOUR  = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [31:0] hash;
    } shf_wb_t;

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [31:0] full_round(input logic [31:0] h_in, input logic [31:0] w);
        logic [31:0] h;
        logic [31:0] t;
        h = h_in + {16'd0, w[15:0]};
        t = {5'd0, w[31:16], 11'd0} ^ h;
        h = {h[15:0], 16'd0} ^ t;
        h = h + {11'd0, h[31:11]};
        return h;
    endfunction

    function automatic logic [31:0] tail3(input logic [31:0] h_in, input logic [31:0] w);
        logic [31:0] h;
        logic [31:0] s;
        s = sext8(w[23:16]);
        h = h_in + {16'd0, w[15:0]};
        h = h ^ {h[15:0], 16'd0};
        h = h ^ {s[13:0], 18'd0};
        h = h + {11'd0, h[31:11]};
        return h;
    endfunction

    function automatic logic [31:0] tail2(input logic [31:0] h_in, input logic [31:0] w);
        logic [31:0] h;
        h = h_in + {16'd0, w[15:0]};
        h = h ^ {h[20:0], 11'd0};
        h = h + {17'd0, h[31:17]};
        return h;
    endfunction

    function automatic logic [31:0] tail1(input logic [31:0] h_in, input logic [31:0] w);
        logic [31:0] h;
        h = h_in + sext8(w[7:0]);
        h = h ^ {h[21:0], 10'd0};
        h = h + {1'b0, h[31:1]};
        return h;
    endfunction

    function automatic logic [31:0] aval_a(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ {h_in[28:0], 3'd0};
        h = h + {5'd0, h[31:5]};
        return h;
    endfunction

    function automatic logic [31:0] aval_b(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ {h_in[27:0], 4'd0};
        h = h + {17'd0, h[31:17]};
        return h;
    endfunction

    function automatic logic [31:0] aval_c(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ {h_in[6:0], 25'd0};
        h = h + {6'd0, h[31:6]};
        return h;
    endfunction

endpackage

FILE: design/shf_front.sv
// Front part: accepts message words, seeds and runs the per-word mixing rounds.
// Pushes the pre-avalanche hash of each last word into the queue. Uses shf_pkg.
module shf_front #(
    parameter int DEPTH = shf_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [31:0]      word,
    input  logic [2:0]       byte_count,
    input  logic             is_first,
    input  logic             is_last,
    input  logic [31:0]      message_length,
    output logic             push,
    output logic [31:0]      push_hash,
    input  logic             queue_full,
    input  shf_pkg::shf_wb_t wb
);

    localparam int FLIGHT_MAX = DEPTH + shf_pkg::AVAL_STAGES + 1;
    localparam int FW         = $clog2(FLIGHT_MAX + 1);

    logic [31:0] run_reg, run_next;
    logic        pend_reg, pend_next;
    logic [FW-1:0] flight_reg, flight_next;

    logic        accept;
    logic [31:0] h_base;
    logic [31:0] h_mix;

    assign in_ready = !queue_full && !(pend_reg && !is_first);
    assign accept   = in_valid && in_ready;
    assign h_base   = is_first ? message_length : run_reg;

    always_comb
    begin
        h_mix = shf_pkg::full_round(h_base, word);
        if (is_last)
        begin
            case (byte_count)
                shf_pkg::CNT_THREE: h_mix = shf_pkg::tail3(h_base, word);
                shf_pkg::CNT_TWO:   h_mix = shf_pkg::tail2(h_base, word);
                shf_pkg::CNT_ONE:   h_mix = shf_pkg::tail1(h_base, word);
                3'd0:               h_mix = h_base;
                default:            h_mix = shf_pkg::full_round(h_base, word);
            endcase
        end
    end

    assign push      = accept && is_last;
    assign push_hash = h_mix;

    always_comb
    begin
        run_next    = run_reg;
        pend_next   = pend_reg;
        flight_next = flight_reg + FW'(push) - FW'(wb.valid);
        if (accept)
        begin
            run_next  = h_mix;
            pend_next = is_last;
        end
        else if (wb.valid && pend_reg && flight_reg == FW'(1))
        begin
            run_next  = wb.hash;
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= '0;
            pend_reg   <= 1'b0;
            flight_reg <= '0;
        end
        else
        begin
            run_reg    <= run_next;
            pend_reg   <= pend_next;
            flight_reg <= flight_next;
        end
    end

endmodule

FILE: design/shf_fifo.sv
// Short queue of pre-avalanche hashes between the front and back parts.
// Register array with read and write pointers; uses shf_pkg.
module shf_fifo #(
    parameter int DEPTH = shf_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [31:0] din,
    output logic        full,
    input  logic        pop,
    output logic [31:0] dout,
    output logic        empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   mem [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full  = cnt_reg == CW'(DEPTH);
    assign empty = cnt_reg == '0;
    assign dout  = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/shf_back.sv
// Back part: three-stage avalanche pipeline ending in the output register.
// Reports each finished hash to the front part. Uses shf_pkg.
module shf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  logic [31:0]      q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      hash_value,
    output shf_pkg::shf_wb_t wb
);

    logic        a_valid_reg, a_valid_next;
    logic        b_valid_reg, b_valid_next;
    logic        c_valid_reg, c_valid_next;
    logic [31:0] a_reg, b_reg, c_reg;
    logic        a_ready, b_ready, c_ready;

    assign c_ready = !c_valid_reg || out_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign q_pop   = !q_empty && a_ready;

    assign a_valid_next = a_ready ? q_pop : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    assign c_valid_next = c_ready ? b_valid_reg : c_valid_reg;

    assign wb.valid = b_valid_reg && c_ready;
    assign wb.hash  = shf_pkg::aval_c(b_reg);

    assign out_valid  = c_valid_reg;
    assign hash_value = c_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_reg <= shf_pkg::aval_a(q_data);
        end
        if (a_valid_reg && b_ready)
        begin
            b_reg <= shf_pkg::aval_b(a_reg);
        end
        if (wb.valid)
        begin
            c_reg <= wb.hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

endmodule

FILE: design/superfasthash_32.sv
// SuperFastHash engine: one message word accepted per cycle while the front does not stall.
// A word without tuser right after a tlast word waits until that hash is written to the output
// register, which can be delayed while m_axis is stalled; it continues from the finished hash.
// Otherwise the front stalls only when the queue between front and avalanche pipeline is full.
// rst_n is asynchronous, active low; it clears the running hash to zero and empties the pipeline.
module superfasthash_32 #(
    parameter int DEPTH = shf_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // word[31:0], byte_count[34:32], message_length[66:35]
    input  logic        s_axis_tuser,  // is_first
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // hash_value[31:0]
);

    logic             push;
    logic [31:0]      push_hash;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [31:0]      q_data;
    shf_pkg::shf_wb_t wb;

    shf_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .word           (s_axis_tdata[31:0]),
        .byte_count     (s_axis_tdata[34:32]),
        .is_first       (s_axis_tuser),
        .is_last        (s_axis_tlast),
        .message_length (s_axis_tdata[66:35]),
        .push           (push),
        .push_hash      (push_hash),
        .queue_full     (q_full),
        .wb             (wb)
    );

    shf_fifo #(
        .DEPTH(DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_hash),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_data),
        .empty (q_empty)
    );

    shf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hash_value (m_axis_tdata),
        .wb         (wb)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for superfasthash_32: streams byte messages and compares each hash
// with an in-bench prediction. Depends on shf_pkg and superfasthash_32.
module tb;

    localparam int RANDOM_WORDS   = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_IDLE       = 13;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        first;
        logic        last;
        logic [31:0] len;
        logic        hold;
    } msg_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    msg_word_t   word_fifo[$];
    logic [31:0] hash_expect[$];
    logic [31:0] hash_state = '0;
    msg_word_t   cur_word;
    int          words_queued = 0;
    int          mismatches = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          idle_cycles = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    superfasthash_32 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] widen_signed(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [31:0] word_round(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] t;
        h = h + {16'd0, w[15:0]};
        t = ({16'd0, w[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [31:0] avalanche_mix(input logic [31:0] h);
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    function automatic void hash_word(input msg_word_t m);
        logic [31:0] h;
        logic [2:0]  n;
        h = m.first ? m.len : hash_state;
        if (!m.last)
        begin
            hash_state = word_round(h, m.word);
        end
        else
        begin
            n = (m.cnt > shf_pkg::CNT_FOUR) ? shf_pkg::CNT_FOUR : m.cnt;
            case (n)
                shf_pkg::CNT_FOUR:  h = word_round(h, m.word);
                shf_pkg::CNT_THREE:
                begin
                    h = h + {16'd0, m.word[15:0]};
                    h = h ^ (h << 16);
                    h = h ^ (widen_signed(m.word[23:16]) << 18);
                    h = h + (h >> 11);
                end
                shf_pkg::CNT_TWO:
                begin
                    h = h + {16'd0, m.word[15:0]};
                    h = h ^ (h << 11);
                    h = h + (h >> 17);
                end
                shf_pkg::CNT_ONE:
                begin
                    h = h + widen_signed(m.word[7:0]);
                    h = h ^ (h << 10);
                    h = h + (h >> 1);
                end
                default: ;
            endcase
            h = avalanche_mix(h);
            hash_state = h;
            hash_expect.push_back(h);
        end
    endfunction

    function automatic int draw_idle(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = ~calm;
        return calm ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 32'h0000_0000;
        if (pick == 1)
            return 32'hFFFF_FFFF;
        if (pick < 7)
            return $urandom | 32'h8080_8080;
        return $urandom;
    endfunction

    task automatic queue_word(input logic [31:0] w, input logic [2:0] cnt, input logic first,
                              input logic last, input logic [31:0] len, input logic hold);
        msg_word_t m;
        m.word  = w;
        m.cnt   = cnt;
        m.first = first;
        m.last  = last;
        m.len   = len;
        m.hold  = hold;
        word_fifo.push_back(m);
        words_queued++;
    endtask

    // Message of nwords words; non-last words carry a random, ignored byte count.
    task automatic queue_msg(input int nwords, input logic [2:0] last_cnt,
                             input logic [31:0] seed, input logic with_first,
                             input logic hold, input logic [31:0] fill, input bit fixed);
        int i;
        for (i = 0; i < nwords; i++)
        begin
            queue_word(fixed ? fill : rand_word(),
                       (i == nwords - 1) ? last_cnt : 3'($urandom_range(0, 7)),
                       (i == 0) ? with_first : 1'b0, i == nwords - 1,
                       ((i == 0) || ($urandom_range(0, 1) == 0)) ? seed : $urandom,
                       (i == 0) ? hold : 1'b0);
        end
    endtask

    task automatic build_directed();
        // continue from the reset value without a start
        queue_msg(2, shf_pkg::CNT_TWO, 32'd0, 1'b0, 1'b0, 32'h1234_5678, 1'b1);
        // empty messages
        queue_msg(1, 3'd0, 32'd0, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1);
        queue_msg(1, 3'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'hA5A5_A5A5, 1'b1);
        // every tail length, with sign-extended bytes
        queue_msg(1, shf_pkg::CNT_ONE, 32'd1, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1);
        queue_msg(1, shf_pkg::CNT_TWO, 32'd2, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1);
        queue_msg(1, shf_pkg::CNT_THREE, 32'd3, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1);
        queue_msg(1, shf_pkg::CNT_FOUR, 32'd4, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1);
        queue_msg(1, shf_pkg::CNT_ONE, 32'd1, 1'b1, 1'b0, 32'hFFFF_FF80, 1'b1);
        queue_msg(1, shf_pkg::CNT_ONE, 32'd1, 1'b1, 1'b0, 32'h0000_007F, 1'b1);
        queue_msg(1, shf_pkg::CNT_THREE, 32'd3, 1'b1, 1'b0, 32'hFF80_0000, 1'b1);
        // byte count above four saturates
        queue_msg(1, 3'd5, 32'd4, 1'b1, 1'b0, 32'h8001_7FFE, 1'b1);
        queue_msg(1, 3'd6, 32'd4, 1'b1, 1'b0, 32'hDEAD_BEEF, 1'b1);
        queue_msg(1, 3'd7, 32'd4, 1'b1, 1'b0, 32'h0F0F_F0F0, 1'b1);
        queue_msg(2, shf_pkg::CNT_FOUR, 32'd8, 1'b1, 1'b0, 32'h0000_0000, 1'b1);
        // length mismatch, sender holds until the pipeline drains
        queue_msg(3, shf_pkg::CNT_FOUR, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
        // continue from the finished hash of the previous message
        queue_msg(1, shf_pkg::CNT_THREE, 32'd0, 1'b0, 1'b0, 32'h00C3_9A21, 1'b1);
        // restart in the middle of a message
        queue_word(32'h1111_2222, 3'd0, 1'b1, 1'b0, 32'd12, 1'b0);
        queue_word(32'h3333_4444, 3'd7, 1'b1, 1'b0, 32'd8, 1'b0);
        queue_word(32'h5555_6666, shf_pkg::CNT_FOUR, 1'b0, 1'b1, 32'd0, 1'b0);
    endtask

    task automatic build_random();
        int          start;
        int          nbytes;
        int          nwords;
        logic [2:0]  tail;
        logic [31:0] seed;
        start = words_queued;
        while (words_queued - start < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                                      : $urandom_range(0, 24);
                nwords = (nbytes == 0) ? 1 : (nbytes + 3) / 4;
                tail   = 3'(nbytes - 4 * (nwords - 1));
                if ($urandom_range(0, 15) == 0)
                    tail = 3'($urandom_range(5, 7));
                seed = ($urandom_range(0, 9) == 0) ? $urandom : nbytes;
                queue_msg(nwords, tail, seed, $urandom_range(0, 19) != 0,
                          $urandom_range(0, 29) == 0, 32'd0, 1'b0);
            end
            else
            begin
                queue_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom),
                           1'($urandom), $urandom, 1'b0);
            end
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        logic vld;
        vld = s_axis_tvalid;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                hash_word(cur_word);
                vld = 1'b0;
            end
            if (!vld)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (word_fifo.size() != 0 &&
                         (!word_fifo[0].hold || hash_expect.size() == 0))
                begin
                    cur_word = word_fifo.pop_front();
                    s_axis_tdata <= {5'd0, cur_word.len, cur_word.cnt, cur_word.word};
                    s_axis_tuser <= cur_word.first;
                    s_axis_tlast <= cur_word.last;
                    vld = 1'b1;
                    send_gap = draw_idle(send_calm);
                end
            end
            s_axis_tvalid <= vld;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (hash_expect.size() == 0)
                begin
                    $error("hash_value: expected none, actual %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = hash_expect.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $error("hash_value: expected %h, actual %h", want, m_axis_tdata);
                        mismatches++;
                    end
                end
                recv_gap = draw_idle(recv_calm);
            end
            if (recv_gap != 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        build_directed();
        build_random();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (word_fifo.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (hash_expect.size() != 0)
            @(posedge clk);
        repeat (shf_pkg::AVAL_STAGES + 2 * MAX_IDLE) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
design/shf_pkg.sv
design/shf_front.sv
design/shf_fifo.sv
design/shf_back.sv
design/superfasthash_32.sv
tb/sv/tb.sv
